>>> hw/rtl/rpmc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpmc_pkg
// Shared widths, limits, state encoding and controller/datapath interface
// types for the red pixel mask and centroid block.
// ----------------------------------------------------------------------------
package rpmc_pkg;

    // frame geometry limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    // field widths
    localparam int COLOR_W = 8;
    localparam int COORD_W = 10;
    localparam int TALLY_W = 21;
    localparam int TOTAL_W = 30;
    localparam int CENT_W  = 10;
    localparam int THR_W   = 8;

    // derived widths
    localparam int DIV_W   = TALLY_W + CENT_W - 1;
    localparam int STEP_W  = $clog2(CENT_W);
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 48;

    // saturation limits
    localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
    localparam logic [CENT_W-1:0]  CENT_MAX  = {CENT_W{1'b1}};

    // register map
    localparam int          APB_ADDR_W   = 2;
    localparam int          APB_DATA_W   = 32;
    localparam logic [APB_ADDR_W-1:0] ADDR_THRESHOLD = 2'd0;
    localparam logic [THR_W-1:0]      THRESHOLD_RESET = 8'd10;

    // controller states
    typedef enum logic [1:0] {
        ST_PIXEL,
        ST_DIVIDE,
        ST_SUMMARY
    } ctrl_state_t;

    // controller to datapath commands
    typedef struct packed {
        logic pixel_take;     // fold accepted pixel into accumulators
        logic frame_close;    // load divider from totals, clear accumulators
        logic div_step;       // one quotient bit for both centroids
        logic load_pixel_out; // output register takes mask-only result
        logic load_summary;   // output register takes frame summary
    } ctrl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic div_last;       // current step is the final quotient bit
    } dp_status_t;

endpackage
`default_nettype wire

>>> hw/rtl/rpmc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpmc_ctrl
// Controller: pixel acceptance, frame-end division sequencing and the
// output valid flag.
// ----------------------------------------------------------------------------
module rpmc_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    input  wire logic                s_tlast,
    output logic                     s_tready,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    input  wire rpmc_pkg::dp_status_t status,
    output rpmc_pkg::ctrl_cmd_t      cmd
);

    rpmc_pkg::ctrl_state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic out_free;
    logic accept;

    // output register can take a new result this cycle
    assign out_free = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    // state and valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rpmc_pkg::ST_PIXEL;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            rpmc_pkg::ST_PIXEL: begin
                s_tready = out_free;
                if (accept) begin
                    cmd.pixel_take = 1'b1;
                    if (s_tlast) begin
                        cmd.frame_close = 1'b1;
                        state_next      = rpmc_pkg::ST_DIVIDE;
                    end else begin
                        cmd.load_pixel_out = 1'b1;
                    end
                end
            end
            rpmc_pkg::ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = rpmc_pkg::ST_SUMMARY;
                end
            end
            rpmc_pkg::ST_SUMMARY: begin
                if (out_free) begin
                    cmd.load_summary = 1'b1;
                    state_next       = rpmc_pkg::ST_PIXEL;
                end
            end
            default: begin
                state_next = rpmc_pkg::ST_PIXEL;
            end
        endcase
    end

    // valid follows loads and downstream takes
    always_comb begin
        if (cmd.load_pixel_out || cmd.load_summary) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // a frame end always starts the division
    a_close_divides: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tlast) |=> (state_reg == rpmc_pkg::ST_DIVIDE))
        else $error("frame end did not start division");

    // no pixel taken while the summary is being formed
    a_no_take_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rpmc_pkg::ST_DIVIDE || state_reg == rpmc_pkg::ST_SUMMARY)
        |-> !s_tready)
        else $error("input ready during division");

    // summary load always presents a result next cycle
    a_summary_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_summary |=> out_valid_reg)
        else $error("summary lost");

    // output register never overwritten while a result waits
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |-> !(cmd.load_pixel_out || cmd.load_summary))
        else $error("pending result overwritten");

endmodule
`default_nettype wire

>>> hw/rtl/rpmc_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpmc_dp
// Datapath: ratio test, saturating accumulators, bit-serial centroid
// divider and the output payload register.
// ----------------------------------------------------------------------------
module rpmc_dp (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic [rpmc_pkg::THR_W-1:0]           threshold,
    input  wire logic [rpmc_pkg::COLOR_W-1:0]         blue,
    input  wire logic [rpmc_pkg::COLOR_W-1:0]         green,
    input  wire logic [rpmc_pkg::COLOR_W-1:0]         red,
    input  wire logic [rpmc_pkg::COORD_W-1:0]         column,
    input  wire logic [rpmc_pkg::COORD_W-1:0]         row,
    input  wire rpmc_pkg::ctrl_cmd_t                  cmd,
    output rpmc_pkg::dp_status_t                      status,
    output logic [rpmc_pkg::OUT_DATA_W-1:0]           out_data,
    output logic                                      out_user
);

    localparam int TW = rpmc_pkg::TALLY_W;
    localparam int SW = rpmc_pkg::TOTAL_W;
    localparam int CW = rpmc_pkg::CENT_W;
    localparam int DW = rpmc_pkg::DIV_W;
    localparam int KW = rpmc_pkg::STEP_W;
    localparam int PROD_W = rpmc_pkg::THR_W + rpmc_pkg::COLOR_W + 3;

    // ratio test: floor((r+1)/(b+g+2)) > t  <=>  r+1 >= (t+1)*(b+g+2)
    logic [rpmc_pkg::THR_W:0]     thr_inc;
    logic [rpmc_pkg::COLOR_W+1:0] den;
    logic [rpmc_pkg::COLOR_W:0]   num;
    logic [PROD_W-1:0]            prod;
    logic                         is_red;

    assign thr_inc = {1'b0, threshold} + 1'b1;
    assign den     = {2'b00, blue} + {2'b00, green} + 2'd2;
    assign num     = {1'b0, red} + 1'b1;
    assign prod    = PROD_W'(thr_inc) * PROD_W'(den);
    assign is_red  = PROD_W'(num) >= prod;

    // coordinate clamp to frame limits
    logic [rpmc_pkg::COORD_W-1:0] col_c, row_c;
    assign col_c = (32'(column) >= 32'(rpmc_pkg::MAX_WIDTH))
                 ? rpmc_pkg::COORD_W'(rpmc_pkg::MAX_WIDTH - 1) : column;
    assign row_c = (32'(row) >= 32'(rpmc_pkg::MAX_HEIGHT))
                 ? rpmc_pkg::COORD_W'(rpmc_pkg::MAX_HEIGHT - 1) : row;

    // saturating accumulator updates
    logic [TW-1:0] tally_reg, tally_next;
    logic [SW-1:0] col_tot_reg, col_tot_next;
    logic [SW-1:0] row_tot_reg, row_tot_next;
    logic [SW:0]   col_sum, row_sum;

    assign col_sum = {1'b0, col_tot_reg} + (SW+1)'(col_c);
    assign row_sum = {1'b0, row_tot_reg} + (SW+1)'(row_c);

    always_comb begin
        tally_next   = tally_reg;
        col_tot_next = col_tot_reg;
        row_tot_next = row_tot_reg;
        if (is_red) begin
            tally_next   = (tally_reg == rpmc_pkg::TALLY_MAX)
                         ? tally_reg : tally_reg + 1'b1;
            col_tot_next = (col_sum > (SW+1)'(rpmc_pkg::TOTAL_MAX))
                         ? rpmc_pkg::TOTAL_MAX : col_sum[SW-1:0];
            row_tot_next = (row_sum > (SW+1)'(rpmc_pkg::TOTAL_MAX))
                         ? rpmc_pkg::TOTAL_MAX : row_sum[SW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tally_reg   <= '0;
            col_tot_reg <= '0;
            row_tot_reg <= '0;
        end else if (cmd.frame_close) begin
            tally_reg   <= '0;
            col_tot_reg <= '0;
            row_tot_reg <= '0;
        end else if (cmd.pixel_take) begin
            tally_reg   <= tally_next;
            col_tot_reg <= col_tot_next;
            row_tot_reg <= row_tot_next;
        end
    end

    // restoring divider, one quotient bit per cycle for both centroids
    logic [TW-1:0] cnt_reg;
    logic [DW-1:0] dvs_reg;
    logic [SW-1:0] col_rem_reg, row_rem_reg;
    logic [CW-1:0] col_q_reg, row_q_reg;
    logic          col_ovf_reg, row_ovf_reg;
    logic          last_red_reg;
    logic [KW-1:0] step_reg;
    logic          col_ge, row_ge;
    logic [SW:0]   dvs_ext;
    logic [SW:0]   lim_ext;

    assign dvs_ext = (SW+1)'(dvs_reg);
    assign col_ge  = {1'b0, col_rem_reg} >= dvs_ext;
    assign row_ge  = {1'b0, row_rem_reg} >= dvs_ext;
    // quotient reaches 2**CENT_W when total >= count << CENT_W
    assign lim_ext = (SW+1)'({tally_next, {CW{1'b0}}});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
        end else if (cmd.frame_close) begin
            step_reg <= '0;
        end else if (cmd.div_step) begin
            step_reg <= step_reg + 1'b1;
        end
    end

    assign status.div_last = (step_reg == KW'(CW - 1));

    always_ff @(posedge aclk) begin
        if (cmd.frame_close) begin
            cnt_reg      <= tally_next;
            dvs_reg      <= {tally_next, {(CW-1){1'b0}}};
            col_rem_reg  <= col_tot_next;
            row_rem_reg  <= row_tot_next;
            col_ovf_reg  <= {1'b0, col_tot_next} >= lim_ext;
            row_ovf_reg  <= {1'b0, row_tot_next} >= lim_ext;
            col_q_reg    <= '0;
            row_q_reg    <= '0;
            last_red_reg <= is_red;
        end else if (cmd.div_step) begin
            if (col_ge) begin
                col_rem_reg <= col_rem_reg - dvs_ext[SW-1:0];
            end
            if (row_ge) begin
                row_rem_reg <= row_rem_reg - dvs_ext[SW-1:0];
            end
            col_q_reg <= {col_q_reg[CW-2:0], col_ge};
            row_q_reg <= {row_q_reg[CW-2:0], row_ge};
            dvs_reg   <= dvs_reg >> 1;
        end
    end

    // summary fields
    logic          blob;
    logic [CW-1:0] cent_col, cent_row;
    assign blob     = (cnt_reg != '0);
    assign cent_col = !blob ? '0 : (col_ovf_reg ? rpmc_pkg::CENT_MAX : col_q_reg);
    assign cent_row = !blob ? '0 : (row_ovf_reg ? rpmc_pkg::CENT_MAX : row_q_reg);

    // output payload register
    logic [rpmc_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic                            out_user_reg;
    localparam int PAD_W = rpmc_pkg::OUT_DATA_W - (2 + TW + 2 * CW);

    always_ff @(posedge aclk) begin
        if (cmd.load_pixel_out) begin
            out_data_reg <= {{(rpmc_pkg::OUT_DATA_W-1){1'b0}}, is_red};
            out_user_reg <= 1'b0;
        end else if (cmd.load_summary) begin
            out_data_reg <= {{PAD_W{1'b0}}, cent_row, cent_col, cnt_reg, blob,
                             last_red_reg};
            out_user_reg <= 1'b1;
        end
    end

    assign out_data = out_data_reg;
    assign out_user = out_user_reg;

endmodule
`default_nettype wire

>>> hw/rtl/red_pixel_mask_centroid.sv
`default_nettype none
// ----------------------------------------------------------------------------
// red_pixel_mask_centroid
// Red pixel mask with per-frame red blob count and centroid.
// ----------------------------------------------------------------------------
// Each pixel gives one result with its red mask bit. Pixels inside a frame
// are taken one per clock cycle while the output side keeps up; the result
// sits in an output register, and a new pixel can enter in the same cycle
// that the previous result is taken, but not while that result is stalled.
// The last pixel of a frame (s_tlast) starts a bit-serial divider that forms
// both centroids, one quotient bit per cycle; no pixel is taken from
// acceptance of that last pixel until the summary is loaded, which also
// waits while the result side stalls; that summary carries the last pixel's
// mask bit, the blob flag, the count and centroids with m_tuser set.
// The ratio threshold sits at byte address 0 of the configuration port and
// should only be written while no pixel is in flight.
// ----------------------------------------------------------------------------
module red_pixel_mask_centroid (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // input stream
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // blue[7:0], green[15:8], red[23:16], column[33:24], row[43:34], zero pad
    input  wire logic [rpmc_pkg::IN_DATA_W-1:0]       s_tdata,
    input  wire logic                                 s_tlast,
    // result stream
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // is_red[0], blob_found[1], red_count[22:2], centroid_column[32:23],
    // centroid_row[42:33], zero pad
    output logic [rpmc_pkg::OUT_DATA_W-1:0]           m_tdata,
    // summary_valid[0]
    output logic                                      m_tuser,
    // configuration port
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [rpmc_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire logic [rpmc_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [rpmc_pkg::APB_DATA_W-1:0]           prdata,
    output logic                                      pready
);

    // threshold register with apb write
    logic [rpmc_pkg::THR_W-1:0] thr_reg;
    logic                       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= rpmc_pkg::THRESHOLD_RESET;
        end else if (cfg_wr && (paddr == rpmc_pkg::ADDR_THRESHOLD)) begin
            thr_reg <= pwdata[rpmc_pkg::THR_W-1:0];
        end
    end

    assign prdata = (paddr == rpmc_pkg::ADDR_THRESHOLD)
                  ? rpmc_pkg::APB_DATA_W'(thr_reg) : '0;

    // input field unpacking
    logic [rpmc_pkg::COLOR_W-1:0] in_blue, in_green, in_red;
    logic [rpmc_pkg::COORD_W-1:0] in_col, in_row;
    assign in_blue  = s_tdata[7:0];
    assign in_green = s_tdata[15:8];
    assign in_red   = s_tdata[23:16];
    assign in_col   = s_tdata[33:24];
    assign in_row   = s_tdata[43:34];

    rpmc_pkg::ctrl_cmd_t  cmd;
    rpmc_pkg::dp_status_t status;

    rpmc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rpmc_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .threshold (thr_reg),
        .blue      (in_blue),
        .green     (in_green),
        .red       (in_red),
        .column    (in_col),
        .row       (in_row),
        .cmd       (cmd),
        .status    (status),
        .out_data  (m_tdata),
        .out_user  (m_tuser)
    );

endmodule
`default_nettype wire
